>>> src/psd_pkg.sv
// Shared types and constants for the partial shuffle draw block.
package psd_pkg;

   localparam int CFG_W     = 7;   // width of each configuration register
   localparam int CSR_IDX_W = 2;   // width of the configuration register index
   localparam int NUM_W     = 7;   // drawn number field
   localparam int POS_W     = 6;   // draw position field

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PICK_COUNT = 2'd1;

   localparam logic [CFG_W-1:0] POOL_SIZE_RST  = 7'd49;
   localparam logic [CFG_W-1:0] PICK_COUNT_RST = 7'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_RD_I,
      S_RD_J,
      S_WR_I,
      S_WR_J,
      S_DLV
   } psd_state_type;

   // status of the serial remainder unit
   typedef struct packed {
      logic busy;
      logic done;
   } psd_div_sts_type;

endpackage

>>> src/partial_shuffle_draw.sv
// Top level of the partial shuffle draw block: control sequencer, marks, remainder unit and pool RAM.
//
//  channel | direction | payload                                       | handshake
//  req     | in        | tdata[RANDOM_BITS-1:0] random_word            | tvalid/tready
//  rsp     | out       | tdata[6:0] drawn_number, [12:7] draw_position | tvalid/tready
//          |           | tlast set_done                                |
//  csr     | in        | csr_index register index, csr_wdata value     | valid/ready
//
// One transaction in gives one transaction out. After acceptance the serial
// remainder unit works one dividend bit a cycle, followed by four RAM accesses
// (read i, read j, write i, write j) and the delivery state, which waits for a
// free output register.
// A new request is taken once the result has moved to the output register,
// so a waiting result does not hold up the next draw. Reset is synchronous;
// it clears the marks, so the pool reads as the identity with no clearing pass.
// CSR writes are always taken and must only land while the block is idle.
module partial_shuffle_draw import psd_pkg::*; #(
   parameter int POOL_MAX    = 64,
   parameter int RANDOM_BITS = 15
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // slave side
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((RANDOM_BITS+7)/8)*8-1:0]     req_tdata,   // [RANDOM_BITS-1:0] random_word
   // master side
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata,   // [6:0] drawn_number, [12:7] draw_position
   output logic                                 rsp_tlast,   // set_done
   // configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [CSR_IDX_W-1:0]                 csr_index,
   input  logic [CFG_W-1:0]                     csr_wdata
);

   localparam int IDX_W = $clog2(POOL_MAX);       // pool position
   localparam int CNT_W = $clog2(POOL_MAX + 1);   // pool count / stored number
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   // configuration registers
   logic [CFG_W-1:0] pool_size_ff, pick_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff  <= POOL_SIZE_RST;
         pick_count_ff <= PICK_COUNT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POOL_SIZE:  pool_size_ff  <= csr_wdata;
            CSR_PICK_COUNT: pick_count_ff <= csr_wdata;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // effective n in 2..POOL_MAX, k in 1..n
   logic [CMP_W-1:0] n_cmp, k_cmp;
   logic [CNT_W-1:0] n_eff, k_eff;

   always_comb begin
      n_cmp = CMP_W'(pool_size_ff);
      if (n_cmp < CMP_W'(2))        n_cmp = CMP_W'(2);
      if (n_cmp > CMP_W'(POOL_MAX)) n_cmp = CMP_W'(POOL_MAX);
      k_cmp = CMP_W'(pick_count_ff);
      if (k_cmp < CMP_W'(1))        k_cmp = CMP_W'(1);
      if (k_cmp > n_cmp)            k_cmp = n_cmp;
      n_eff = CNT_W'(n_cmp);
      k_eff = CNT_W'(k_cmp);
   end

   // control state
   psd_state_type        state_ff, state_in;
   logic [IDX_W-1:0]     step_ff, step_in;
   logic [POOL_MAX-1:0]  marks_ff, marks_in;
   logic [IDX_W-1:0]     i_ff, i_in;
   logic [IDX_W-1:0]     j_ff, j_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [CNT_W-1:0]     a_ff, a_in;
   logic [CNT_W-1:0]     b_ff, b_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]     rsp_num_ff, rsp_num_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic                 rsp_last_ff, rsp_last_in;

   // remainder unit and pool RAM hookup
   logic                 div_start;
   logic [CNT_W-1:0]     div_divisor;
   logic [CNT_W-1:0]     div_rem;
   psd_div_sts_type      div_sts;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [CNT_W-1:0]     ram_wr_data;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [CNT_W-1:0]     ram_rd_data;

   logic                 slot_free;
   logic                 restart;
   logic                 last_draw;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   // step at or past k (k lowered mid-set): treat as step 0 of a fresh set
   assign restart   = CNT_W'(step_ff) >= k_eff;
   assign last_draw = (CNT_W'(i_ff) + CNT_W'(1)) == k_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      marks_in     = marks_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_num_in   = rsp_num_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      div_start    = 1'b0;
      div_divisor  = n_eff - CNT_W'(restart ? '0 : step_ff);
      ram_wr_en    = 1'b0;
      ram_wr_addr  = i_ff;
      ram_wr_data  = b_ff;
      ram_rd_addr  = i_ff;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               div_start = 1'b1;
               k_in      = k_eff;
               if (restart) begin
                  marks_in = '0;
                  i_in     = '0;
               end else begin
                  i_in     = step_ff;
               end
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_sts.done) begin
               j_in     = IDX_W'(CNT_W'(i_ff) + div_rem);
               state_in = S_RD_I;
            end
         end
         S_RD_I: begin
            ram_rd_addr = i_ff;
            state_in    = S_RD_J;
         end
         S_RD_J: begin
            // read data of entry i arrives now
            ram_rd_addr = j_ff;
            a_in        = marks_ff[i_ff] ? ram_rd_data : CNT_W'(i_ff) + CNT_W'(1);
            state_in    = S_WR_I;
         end
         S_WR_I: begin
            b_in            = marks_ff[j_ff] ? ram_rd_data : CNT_W'(j_ff) + CNT_W'(1);
            ram_wr_en       = 1'b1;
            ram_wr_addr     = i_ff;
            ram_wr_data     = b_in;
            marks_in[i_ff]  = 1'b1;
            state_in        = S_WR_J;
         end
         S_WR_J: begin
            ram_wr_en       = 1'b1;
            ram_wr_addr     = j_ff;
            ram_wr_data     = a_ff;
            marks_in[j_ff]  = 1'b1;
            state_in        = S_DLV;
         end
         S_DLV: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = NUM_W'(b_ff);
               rsp_pos_in   = POS_W'(i_ff);
               rsp_last_in  = last_draw;
               if (last_draw) begin
                  // set complete: pool back to identity
                  marks_in = '0;
                  step_in  = '0;
               end else begin
                  step_in  = i_ff + IDX_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         marks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         marks_ff     <= marks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   psd_mod #(
      .DIVIDEND_W (RANDOM_BITS),
      .DIVISOR_W  (CNT_W)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[RANDOM_BITS-1:0]),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .rem      (div_rem)
   );

   psd_ram #(
      .WIDTH (CNT_W),
      .DEPTH (POOL_MAX)
   ) u_pool (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_pos_ff, rsp_num_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_sts.busy)
      else $error("remainder unit busy while sequencer idle");

   a_step_in_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DLV) |-> (CNT_W'(i_ff) < k_ff && CNT_W'(j_ff) >= CNT_W'(i_ff)))
      else $error("draw step or swap partner out of range");

   a_set_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DLV && slot_free && last_draw) |=> (marks_ff == '0 && step_ff == '0))
      else $error("pool not returned to identity after last draw");

   a_marks_after_swap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR_J) |=> (marks_ff[i_ff] && marks_ff[j_ff]))
      else $error("swapped entries not marked as written");

endmodule

>>> src/psd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module psd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/psd_mod.sv
// Restoring serial remainder unit: one dividend bit per cycle.
module psd_mod import psd_pkg::*; #(
   parameter int DIVIDEND_W = 15,
   parameter int DIVISOR_W  = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output psd_div_sts_type       sts,
   output logic [DIVISOR_W-1:0]  rem
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // partial remainder stays below the divisor, so trial < 2 * divisor
   assign trial = {rem_ff, shift_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = STEP_W'(DIVIDEND_W);
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? DIVISOR_W'(trial - {1'b0, div_ff}) : DIVISOR_W'(trial);
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign rem      = rem_ff;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("remainder unit busy and done together");

endmodule

>>> sim/tb_partial_shuffle_draw.sv
// Self-checking testbench for the partial shuffle draw block.
`timescale 1ns / 100ps

module tb_partial_shuffle_draw import psd_pkg::*;;

   localparam int POOL_DEPTH   = 64;
   localparam int WORD_W       = 15;
   localparam int HOLD_CYCLES  = 300;       // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES = 60;        // quiet time after the last expected result, for stray results
   localparam int CYCLE_LIMIT  = 500_000;   // watchdog limit, well above the slowest legal run

   // register indexes the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [NUM_W-1:0] number;
      logic [POS_W-1:0] position;
      logic             last;
   } draw_result_type;

   localparam draw_result_type NO_RES = '0;

   // directed table: config write, draw checked by the model, or draw with typed result
   typedef enum logic [1:0] {ROW_CSR, ROW_DRAW, ROW_TYPED} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [WORD_W-1:0]    arg;     // register value or random word
      draw_result_type      res;     // typed result, ROW_TYPED only
   } stim_row_type;

   stim_row_type directed_rows [29] = '{
      // reset settings, 49 numbers, 6 picks; word 0 keeps entry 0 in place
      '{ROW_TYPED, '0, 15'd0,     '{7'd1, 6'd0, 1'b0}},
      '{ROW_DRAW,  '0, 15'h7FFF,  NO_RES},
      '{ROW_DRAW,  '0, 15'd1,     NO_RES},
      '{ROW_DRAW,  '0, 15'h3039,  NO_RES},
      '{ROW_DRAW,  '0, 15'h5555,  NO_RES},
      '{ROW_DRAW,  '0, 15'h2AAA,  NO_RES},
      // pool size below range saturates to 2, pick count above pool to 2
      '{ROW_CSR,   CSR_POOL_SIZE,  15'd0,   NO_RES},
      '{ROW_CSR,   CSR_PICK_COUNT, 15'd127, NO_RES},
      '{ROW_TYPED, '0, 15'd0,     '{7'd1, 6'd0, 1'b0}},
      '{ROW_TYPED, '0, 15'd0,     '{7'd2, 6'd1, 1'b1}},
      // pool size above range saturates to 64, pick count 0 to 1
      '{ROW_CSR,   CSR_POOL_SIZE,  15'd127, NO_RES},
      '{ROW_CSR,   CSR_PICK_COUNT, 15'd0,   NO_RES},
      '{ROW_TYPED, '0, 15'h7FFF,  '{7'd64, 6'd0, 1'b1}},
      '{ROW_TYPED, '0, 15'd5,     '{7'd6, 6'd0, 1'b1}},
      // full pool, long set, then shrink the pick count under the step index
      '{ROW_CSR,   CSR_PICK_COUNT, 15'd64,  NO_RES},
      '{ROW_DRAW,  '0, 15'h7FFF,  NO_RES},
      '{ROW_DRAW,  '0, 15'h7000,  NO_RES},
      '{ROW_DRAW,  '0, 15'd100,   NO_RES},
      '{ROW_DRAW,  '0, 15'h0FFF,  NO_RES},
      '{ROW_DRAW,  '0, 15'd63,    NO_RES},
      '{ROW_CSR,   CSR_PICK_COUNT, 15'd3,   NO_RES},
      '{ROW_TYPED, '0, 15'd0,     '{7'd1, 6'd0, 1'b0}},
      // writes to unused indexes change nothing
      '{ROW_CSR,   CSR_SPARE_A,    15'd127, NO_RES},
      '{ROW_CSR,   CSR_SPARE_B,    15'h55,  NO_RES},
      '{ROW_DRAW,  '0, 15'd777,   NO_RES},
      '{ROW_DRAW,  '0, 15'h7FFF,  NO_RES},
      // smallest pool, single pick: odd word takes the second entry
      '{ROW_CSR,   CSR_POOL_SIZE,  15'd1,   NO_RES},
      '{ROW_CSR,   CSR_PICK_COUNT, 15'd1,   NO_RES},
      '{ROW_TYPED, '0, 15'h7FFF,  '{7'd2, 6'd0, 1'b1}}
   };

   // idling per random phase: receiver idles most first, then sender, then neither
   int unsigned send_idle_pct [3] = '{15, 75, 0};
   int unsigned recv_idle_pct [3] = '{75, 15, 0};

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata  = '0;     // [14:0] random_word
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;           // [6:0] drawn_number, [12:7] draw_position
   logic                 rsp_tlast;           // set_done
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]     csr_wdata  = '0;

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   bit          hold_go      = 1'b0;
   logic        rsp_hold     = 1'b0;
   int unsigned cycle_count  = 0;
   int unsigned mismatches   = 0;
   int unsigned draws_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned sets_done    = 0;

   // predictor state: shadow pool, written marks, step and both registers
   logic [NUM_W-1:0] pool_mirror [POOL_DEPTH];
   bit               touched     [POOL_DEPTH];
   int unsigned      step_mirror;
   logic [CFG_W-1:0] size_reg;
   logic [CFG_W-1:0] count_reg;

   // results awaited from the block, oldest first
   draw_result_type pending_draws [$];

   partial_shuffle_draw #(
      .POOL_MAX    (POOL_DEPTH),
      .RANDOM_BITS (WORD_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $time, pending_draws.size());
         $display("tb_partial_shuffle_draw failed");
         $finish;
      end
   end

   // back to the identity pool, step 0
   function automatic void clear_pool();
      foreach (touched[x])
         touched[x] = 1'b0;
      step_mirror = 0;
   endfunction

   // entries never written since the last clear read as index + 1
   function automatic logic [NUM_W-1:0] pool_value(int unsigned idx);
      return touched[idx] ? pool_mirror[idx] : NUM_W'(idx + 1);
   endfunction

   // one Fisher-Yates step: swap entries i and j, report the number now at i
   task automatic draw_predict(input logic [WORD_W-1:0] word, output draw_result_type res);
      int unsigned      n;
      int unsigned      k;
      int unsigned      i;
      int unsigned      j;
      logic [NUM_W-1:0] at_i;
      logic [NUM_W-1:0] at_j;
      n = size_reg;
      if (n < 2)
         n = 2;
      if (n > POOL_DEPTH)
         n = POOL_DEPTH;
      k = count_reg;
      if (k < 1)
         k = 1;
      if (k > n)
         k = n;
      // registers shrunk under the running set: start a new one
      if (step_mirror >= k)
         clear_pool();
      i = step_mirror;
      j = i + (int'(word) % (n - i));
      at_i = pool_value(i);
      at_j = pool_value(j);
      pool_mirror[i] = at_j;
      touched[i]     = 1'b1;
      pool_mirror[j] = at_i;
      touched[j]     = 1'b1;
      res.number   = at_j;
      res.position = POS_W'(i);
      res.last     = (i + 1 == k);
      if (res.last)
         clear_pool();
      else
         step_mirror = i + 1;
   endtask

   // register write, only once every outstanding result has been taken
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      req_tvalid <= 1'b0;
      while (pending_draws.size() != 0)
         @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_POOL_SIZE:  size_reg  = val;
         CSR_PICK_COUNT: count_reg = val;
         default: ;
      endcase
   endtask

   // offer one random word; valid stays high into the next transaction unless we idle
   task automatic send_word(input logic [WORD_W-1:0] word, input bit typed,
                            input draw_result_type typed_res);
      draw_result_type res;
      csr_valid <= 1'b0;
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, word};
      do @(posedge clock); while (!req_tready);
      draw_predict(word, res);
      pending_draws.push_back(typed ? typed_res : res);
      draws_sent++;
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return WORD_W'($urandom_range(63));
         default: return WORD_W'($urandom_range(32767));
      endcase
   endfunction

   // new pool size and pick count, with saturating values and extremes mixed in
   task automatic set_random_config();
      logic [CFG_W-1:0] size_val;
      logic [CFG_W-1:0] count_val;
      case ($urandom_range(7))
         0:       size_val = 7'd2;
         1:       size_val = 7'd64;
         2:       size_val = CFG_W'($urandom_range(1));
         3:       size_val = CFG_W'($urandom_range(127, 65));
         default: size_val = CFG_W'($urandom_range(64, 2));
      endcase
      case ($urandom_range(7))
         0:       count_val = 7'd1;
         1:       count_val = 7'd64;
         2:       count_val = 7'd0;
         3:       count_val = CFG_W'($urandom_range(127, 65));
         default: count_val = CFG_W'($urandom_range(12, 1));
      endcase
      if ($urandom_range(1)) begin
         write_reg(CSR_POOL_SIZE, size_val);
         write_reg(CSR_PICK_COUNT, count_val);
      end else begin
         write_reg(CSR_PICK_COUNT, count_val);
         write_reg(CSR_POOL_SIZE, size_val);
      end
      if ($urandom_range(3) == 0)
         write_reg($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, CFG_W'($urandom_range(127)));
   endtask

   // receiver: random stalls, or solid hold-off while rsp_hold is up
   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   // one long hold-off; the sender keeps offering so the block backs up to req_tready
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic void check_field(input string what, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endfunction

   // result monitor: every rsp transaction against the oldest expectation
   always @(posedge clock) begin
      draw_result_type got;
      draw_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.number   = rsp_tdata[NUM_W-1:0];
         got.position = rsp_tdata[NUM_W +: POS_W];
         got.last     = rsp_tlast;
         results_seen++;
         if (got.last)
            sets_done++;
         if (pending_draws.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %0d pos %0d last %0b",
                     $time, got.number, got.position, got.last);
         end else begin
            want = pending_draws.pop_front();
            check_field("drawn_number",  want.number,   got.number);
            check_field("draw_position", want.position, got.position);
            check_field("set_done",      want.last,     got.last);
         end
      end
   end

   initial begin
      size_reg  = POOL_SIZE_RST;
      count_reg = PICK_COUNT_RST;
      clear_pool();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            ROW_CSR:   write_reg(directed_rows[r].idx, CFG_W'(directed_rows[r].arg));
            ROW_DRAW:  send_word(directed_rows[r].arg, 1'b0, NO_RES);
            ROW_TYPED: send_word(directed_rows[r].arg, 1'b1, directed_rows[r].res);
            default: ;
         endcase
      end

      // random part: three idling phases, fresh settings every 50 draws
      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = send_idle_pct[phase];
         rsp_idle_pct = recv_idle_pct[phase];
         for (int blk = 0; blk < 5; blk++) begin
            set_random_config();
            // start the hold-off while the sender is busy and settings are fixed
            if (phase == 0 && blk == 1)
               hold_go = 1'b1;
            repeat (50)
               send_word(random_word(), 1'b0, NO_RES);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_draws.size() != 0)
         @(posedge clock);
      // catch any stray result after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d draws sent, %0d results checked over %0d complete sets, %0d mismatches",
               draws_sent, results_seen, sets_done, mismatches);
      $display("covered pool/pick extremes and saturation, unused indexes, mid-set changes, back-pressure");
      if (mismatches == 0)
         $display("tb_partial_shuffle_draw passed");
      else
         $display("tb_partial_shuffle_draw failed");
      $finish;
   end

endmodule

>>> sim.f
src/psd_pkg.sv
src/psd_ram.sv
src/psd_mod.sv
src/partial_shuffle_draw.sv
sim/tb_partial_shuffle_draw.sv
